// ===== rtl/core/binary_min_heap_queue_top_defines.svh =====
// Assertion macros shared by the heap queue checker.
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BMHQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bmhq_pkg.sv =====
// Types and constants of the binary min-heap queue.
`timescale 1ns / 1ps
package bmhq_pkg;

  localparam int ACT_W   = 2;
  localparam int KEY_W   = 32;
  localparam int PAY_W   = 32;
  localparam int TOTAL_W = 11;
  localparam int CAP_W   = 11;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_EXTRACT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_APPEND  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_REBUILD = 2'd3;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_SIGNED   = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_EX_RD0,
    ST_EX_RDL,
    ST_EX_GOT,
    ST_RB_RD,
    ST_RB_GOT,
    ST_DN_L,
    ST_DN_R,
    ST_DN_RC,
    ST_DN_C,
    ST_DN_END,
    ST_DONE
  } bmhq_state_t;

endpackage

// ===== rtl/core/bmhq_if.sv =====
// Valid/ready channel interfaces for heap queue items and results.
`timescale 1ns / 1ps
interface bmhq_in_if;
  logic                        valid;
  logic                        ready;
  logic [bmhq_pkg::ACT_W-1:0]  action;
  logic [bmhq_pkg::KEY_W-1:0]  in_key;
  logic [bmhq_pkg::PAY_W-1:0]  in_payload;

  modport source (output valid, action, in_key, in_payload, input ready);
  modport sink   (input valid, action, in_key, in_payload, output ready);
endinterface

interface bmhq_out_if;
  logic                         valid;
  logic                         ready;
  logic                         out_valid;
  logic [bmhq_pkg::KEY_W-1:0]   out_key;
  logic [bmhq_pkg::PAY_W-1:0]   out_payload;
  logic                         dropped;
  logic [bmhq_pkg::TOTAL_W-1:0] entry_total;

  modport source (output valid, out_valid, out_key, out_payload, dropped, entry_total,
                  input ready);
  modport sink   (input valid, out_valid, out_key, out_payload, dropped, entry_total,
                  output ready);
endinterface

// ===== rtl/core/bmhq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bmhq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bmhq_cmp.sv =====
// Shared key comparator: strict less-than, unsigned or two's complement.
`timescale 1ns / 1ps
module bmhq_cmp #(
  parameter int KEY_BITS = 32
) (
  input  logic [KEY_BITS-1:0] a,
  input  logic [KEY_BITS-1:0] b,
  input  logic                signed_keys,
  output logic                less
);

  logic [KEY_BITS-1:0] flip;

  // Flipping the sign bit turns a signed order into an unsigned one.
  assign flip = {signed_keys, {(KEY_BITS-1){1'b0}}};
  assign less = (a ^ flip) < (b ^ flip);

endmodule

// ===== rtl/core/binary_min_heap_queue_top.sv =====
// Top level of the binary min-heap queue: config registers, sequencer, heap RAM.
//
//   Channel  Dir  Handshake          Content
//   in_ch    in   valid/ready        action, in_key, in_payload
//   out_ch   out  valid/ready        out_valid, out_key, out_payload, dropped, entry_total
//   cfg_*    in   APB write/read     capacity_limit at 0x0, signed_keys at 0x4
//
// One item at a time; every heap step goes through the single RAM read port and
// the one shared key comparator. Append, drops and empty extracts go from DECIDE
// straight to DONE; insert climbs through UP_CHK and UP_CMP for each level, extract
// reads the root and the last entry and then descends through DN_L, DN_R, DN_RC and
// DN_C, and rebuild runs that descent for every parent from the last one to the root.
// rst_n is synchronous; the RAM needs no clearing. A finished item holds in DONE
// while the previous result is unread; the next item is taken while a result waits.
`timescale 1ns / 1ps
module binary_min_heap_queue_top #(
  parameter int DEPTH        = 1024,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bmhq_in_if.sink                       in_ch,
  bmhq_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bmhq_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [bmhq_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [bmhq_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int EW   = KEY_BITS + PAYLOAD_BITS;
  localparam int FW   = (CW > bmhq_pkg::CAP_W) ? CW : bmhq_pkg::CAP_W;

  // Configuration registers.
  logic [bmhq_pkg::CAP_W-1:0] cap_r;
  logic                       sgn_r;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bmhq_pkg::CAP_RESET;
      sgn_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        bmhq_pkg::REG_CAPACITY: cap_r <= cfg_pwdata[bmhq_pkg::CAP_W-1:0];
        bmhq_pkg::REG_SIGNED:   sgn_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      bmhq_pkg::REG_CAPACITY: cfg_prdata = bmhq_pkg::APB_DW'(cap_r);
      bmhq_pkg::REG_SIGNED:   cfg_prdata = bmhq_pkg::APB_DW'(sgn_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // Sequencer state.
  bmhq_pkg::bmhq_state_t state_r, state_nxt;

  logic [bmhq_pkg::ACT_W-1:0] act_r, act_nxt;
  logic [EW-1:0]              in_ent_r, in_ent_nxt;
  logic [EW-1:0]              cur_r, cur_nxt;
  logic [EW-1:0]              pick_r, pick_nxt;
  logic [AW-1:0]              pick_idx_r, pick_idx_nxt;
  logic [AW-1:0]              pos_r, pos_nxt;
  logic [AW-1:0]              rb_idx_r, rb_idx_nxt;
  logic [CW-1:0]              count_r, count_nxt;

  logic                       hit_r, hit_nxt;
  logic                       drop_r, drop_nxt;
  logic [bmhq_pkg::KEY_W-1:0] rkey_r, rkey_nxt;
  logic [bmhq_pkg::PAY_W-1:0] rpay_r, rpay_nxt;

  logic                         ov_r, ov_nxt;
  logic                         o_hit_r, o_hit_nxt;
  logic                         o_drop_r, o_drop_nxt;
  logic [bmhq_pkg::KEY_W-1:0]   o_key_r, o_key_nxt;
  logic [bmhq_pkg::PAY_W-1:0]   o_pay_r, o_pay_nxt;
  logic [bmhq_pkg::TOTAL_W-1:0] o_total_r, o_total_nxt;

  // RAM and comparator hookup.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [KEY_BITS-1:0] cmp_a, cmp_b;
  logic          less;

  bmhq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bmhq_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
    .a           (cmp_a),
    .b           (cmp_b),
    .signed_keys (sgn_r),
    .less        (less)
  );

  // Index arithmetic for the heap walk.
  logic [CW:0]         lt_w, rt_w, cnt_w;
  logic                has_l, has_r, full_w, resolve;
  logic [AW-1:0]       par_w;
  logic [KEY_BITS-1:0] rd_key, cur_key, pick_key;

  assign lt_w    = (CW+1)'({pos_r, 1'b1});
  assign rt_w    = lt_w + (CW+1)'(1);
  assign cnt_w   = (CW+1)'(count_r);
  assign has_l   = lt_w < cnt_w;
  assign has_r   = rt_w < cnt_w;
  assign par_w   = AW'((pos_r - AW'(1)) >> 1);
  assign full_w  = (FW'(count_r) >= FW'(cap_r)) || (32'(count_r) >= DEPTH);
  assign rd_key  = ram_rdata[EW-1 -: KEY_BITS];
  assign cur_key = cur_r[EW-1 -: KEY_BITS];
  assign pick_key = pick_r[EW-1 -: KEY_BITS];
  assign resolve = !ov_r || out_ch.ready;

  always_comb begin
    case (state_r)
      bmhq_pkg::ST_UP_CMP: begin
        cmp_a = rd_key;
        cmp_b = cur_key;
      end
      bmhq_pkg::ST_DN_RC: begin
        cmp_a = pick_key;
        cmp_b = rd_key;
      end
      default: begin
        cmp_a = cur_key;
        cmp_b = pick_key;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmhq_pkg::ST_IDLE:
        if (in_ch.valid) state_nxt = bmhq_pkg::ST_DECIDE;
      bmhq_pkg::ST_DECIDE: begin
        unique case (act_r)
          bmhq_pkg::ACT_INSERT:
            state_nxt = full_w ? bmhq_pkg::ST_DONE : bmhq_pkg::ST_UP_CHK;
          bmhq_pkg::ACT_APPEND:
            state_nxt = bmhq_pkg::ST_DONE;
          bmhq_pkg::ACT_EXTRACT:
            state_nxt = (count_r == '0) ? bmhq_pkg::ST_DONE : bmhq_pkg::ST_EX_RD0;
          bmhq_pkg::ACT_REBUILD:
            state_nxt = (count_r <= CW'(1)) ? bmhq_pkg::ST_DONE : bmhq_pkg::ST_RB_RD;
          default: state_nxt = bmhq_pkg::ST_DONE;
        endcase
      end
      bmhq_pkg::ST_UP_CHK:
        state_nxt = (pos_r == '0) ? bmhq_pkg::ST_DONE : bmhq_pkg::ST_UP_CMP;
      bmhq_pkg::ST_UP_CMP:
        state_nxt = less ? bmhq_pkg::ST_DONE : bmhq_pkg::ST_UP_CHK;
      bmhq_pkg::ST_EX_RD0: state_nxt = bmhq_pkg::ST_EX_RDL;
      bmhq_pkg::ST_EX_RDL: state_nxt = bmhq_pkg::ST_EX_GOT;
      bmhq_pkg::ST_EX_GOT: state_nxt = bmhq_pkg::ST_DN_L;
      bmhq_pkg::ST_RB_RD:  state_nxt = bmhq_pkg::ST_RB_GOT;
      bmhq_pkg::ST_RB_GOT: state_nxt = bmhq_pkg::ST_DN_L;
      bmhq_pkg::ST_DN_L:
        state_nxt = has_l ? bmhq_pkg::ST_DN_R : bmhq_pkg::ST_DN_END;
      bmhq_pkg::ST_DN_R:
        state_nxt = has_r ? bmhq_pkg::ST_DN_RC : bmhq_pkg::ST_DN_C;
      bmhq_pkg::ST_DN_RC:  state_nxt = bmhq_pkg::ST_DN_C;
      bmhq_pkg::ST_DN_C:
        state_nxt = less ? bmhq_pkg::ST_DN_END : bmhq_pkg::ST_DN_L;
      bmhq_pkg::ST_DN_END:
        state_nxt = (act_r == bmhq_pkg::ACT_REBUILD && rb_idx_r != '0) ?
                    bmhq_pkg::ST_RB_RD : bmhq_pkg::ST_DONE;
      bmhq_pkg::ST_DONE:
        if (resolve) state_nxt = bmhq_pkg::ST_IDLE;
      default: state_nxt = bmhq_pkg::ST_IDLE;
    endcase
  end

  // Datapath and RAM control. The walk keeps the moving entry in cur_r and
  // writes it only once its final slot is known.
  always_comb begin
    act_nxt      = act_r;
    in_ent_nxt   = in_ent_r;
    cur_nxt      = cur_r;
    pick_nxt     = pick_r;
    pick_idx_nxt = pick_idx_r;
    pos_nxt      = pos_r;
    rb_idx_nxt   = rb_idx_r;
    count_nxt    = count_r;
    hit_nxt      = hit_r;
    drop_nxt     = drop_r;
    rkey_nxt     = rkey_r;
    rpay_nxt     = rpay_r;
    ram_we       = 1'b0;
    ram_waddr    = pos_r;
    ram_wdata    = cur_r;
    ram_raddr    = '0;
    in_ch.ready  = 1'b0;

    unique case (state_r)
      bmhq_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        act_nxt     = in_ch.action;
        in_ent_nxt  = {KEY_BITS'(in_ch.in_key), PAYLOAD_BITS'(in_ch.in_payload)};
      end
      bmhq_pkg::ST_DECIDE: begin
        hit_nxt  = 1'b0;
        drop_nxt = 1'b0;
        rkey_nxt = '0;
        rpay_nxt = '0;
        unique case (act_r) inside
          bmhq_pkg::ACT_INSERT, bmhq_pkg::ACT_APPEND: begin
            if (full_w) begin
              drop_nxt = 1'b1;
            end else begin
              count_nxt = count_r + CW'(1);
              cur_nxt   = in_ent_r;
              pos_nxt   = AW'(count_r);
              if (act_r == bmhq_pkg::ACT_APPEND) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(count_r);
                ram_wdata = in_ent_r;
              end
            end
          end
          bmhq_pkg::ACT_REBUILD:
            rb_idx_nxt = AW'((count_r - CW'(1)) >> 1);
          default: ;
        endcase
      end
      bmhq_pkg::ST_UP_CHK: begin
        if (pos_r == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_raddr = par_w;
        end
      end
      bmhq_pkg::ST_UP_CMP: begin
        ram_we = 1'b1;
        if (!less) begin
          ram_wdata = ram_rdata;
          pos_nxt   = par_w;
        end
      end
      bmhq_pkg::ST_EX_RD0: ram_raddr = '0;
      bmhq_pkg::ST_EX_RDL: begin
        ram_raddr = AW'(count_r - CW'(1));
        hit_nxt   = 1'b1;
        rkey_nxt  = bmhq_pkg::KEY_W'(rd_key);
        rpay_nxt  = bmhq_pkg::PAY_W'(ram_rdata[PAYLOAD_BITS-1:0]);
      end
      bmhq_pkg::ST_EX_GOT: begin
        cur_nxt   = ram_rdata;
        count_nxt = count_r - CW'(1);
        pos_nxt   = '0;
      end
      bmhq_pkg::ST_RB_RD: ram_raddr = rb_idx_r;
      bmhq_pkg::ST_RB_GOT: begin
        cur_nxt = ram_rdata;
        pos_nxt = rb_idx_r;
      end
      bmhq_pkg::ST_DN_L: begin
        if (has_l) begin
          ram_raddr = lt_w[AW-1:0];
        end else begin
          ram_we = 1'b1;
        end
      end
      bmhq_pkg::ST_DN_R: begin
        pick_nxt     = ram_rdata;
        pick_idx_nxt = lt_w[AW-1:0];
        if (has_r) ram_raddr = rt_w[AW-1:0];
      end
      bmhq_pkg::ST_DN_RC: begin
        // Left wins only when strictly less than right.
        if (!less) begin
          pick_nxt     = ram_rdata;
          pick_idx_nxt = rt_w[AW-1:0];
        end
      end
      bmhq_pkg::ST_DN_C: begin
        ram_we = 1'b1;
        if (!less) begin
          ram_wdata = pick_r;
          pos_nxt   = pick_idx_r;
        end
      end
      bmhq_pkg::ST_DN_END: begin
        if (act_r == bmhq_pkg::ACT_REBUILD && rb_idx_r != '0) begin
          rb_idx_nxt = rb_idx_r - AW'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_comb begin
    ov_nxt      = ov_r;
    o_hit_nxt   = o_hit_r;
    o_drop_nxt  = o_drop_r;
    o_key_nxt   = o_key_r;
    o_pay_nxt   = o_pay_r;
    o_total_nxt = o_total_r;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    if (state_r == bmhq_pkg::ST_DONE && resolve) begin
      ov_nxt      = 1'b1;
      o_hit_nxt   = hit_r;
      o_drop_nxt  = drop_r;
      o_key_nxt   = rkey_r;
      o_pay_nxt   = rpay_r;
      o_total_nxt = bmhq_pkg::TOTAL_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmhq_pkg::ST_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    in_ent_r   <= in_ent_nxt;
    cur_r      <= cur_nxt;
    pick_r     <= pick_nxt;
    pick_idx_r <= pick_idx_nxt;
    pos_r      <= pos_nxt;
    rb_idx_r   <= rb_idx_nxt;
    hit_r      <= hit_nxt;
    drop_r     <= drop_nxt;
    rkey_r     <= rkey_nxt;
    rpay_r     <= rpay_nxt;
    o_hit_r    <= o_hit_nxt;
    o_drop_r   <= o_drop_nxt;
    o_key_r    <= o_key_nxt;
    o_pay_r    <= o_pay_nxt;
    o_total_r  <= o_total_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.out_valid   = o_hit_r;
  assign out_ch.out_key     = o_key_r;
  assign out_ch.out_payload = o_pay_r;
  assign out_ch.dropped     = o_drop_r;
  assign out_ch.entry_total = o_total_r;

endmodule

// ===== rtl/core/bmhq_chk.sv =====
// Port-level checker for the heap queue, bound to the top level.
`timescale 1ns / 1ps
`include "binary_min_heap_queue_top_defines.svh"
module bmhq_chk #(
  parameter int DEPTH = 1024
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_vld,
  input logic                         out_rdy,
  input logic                         out_hit,
  input logic [bmhq_pkg::KEY_W-1:0]   out_key,
  input logic [bmhq_pkg::PAY_W-1:0]   out_payload,
  input logic                         out_dropped,
  input logic [bmhq_pkg::TOTAL_W-1:0] out_total
);

  `BMHQ_ASSERT_NEXT(a_out_hold, out_vld && !out_rdy, out_vld,
    "result withdrawn before transfer")
  `BMHQ_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
    "second item taken while one is in work")
  `BMHQ_ASSERT_NOW(a_hit_no_drop, out_vld, !(out_hit && out_dropped),
    "extract result flagged as dropped")
  `BMHQ_ASSERT_NOW(a_miss_zero, out_vld && !out_hit, out_key == '0 && out_payload == '0,
    "empty result carries nonzero data")
  `BMHQ_ASSERT_NOW(a_total_bound, out_vld, 32'(out_total) <= DEPTH,
    "entry total exceeds heap depth")

endmodule

bind binary_min_heap_queue_top bmhq_chk #(.DEPTH(DEPTH)) u_bmhq_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_vld     (out_ch.valid),
  .out_rdy     (out_ch.ready),
  .out_hit     (out_ch.out_valid),
  .out_key     (out_ch.out_key),
  .out_payload (out_ch.out_payload),
  .out_dropped (out_ch.dropped),
  .out_total   (out_ch.entry_total)
);
